// File: rtl/core/tcw_pkg.sv
// Package for the text console writer: geometry, command codes, FSM states, shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam logic [7:0] BLANK = 8'h20;

    localparam logic [2:0] K_PUT   = 3'd0;
    localparam logic [2:0] K_BS    = 3'd1;
    localparam logic [2:0] K_SET   = 3'd2;
    localparam logic [2:0] K_MOVE  = 3'd3;
    localparam logic [2:0] K_CELL  = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;
    localparam logic [2:0] K_READ  = 3'd6;

    localparam logic [1:0] D_UP    = 2'd0;
    localparam logic [1:0] D_DOWN  = 2'd1;
    localparam logic [1:0] D_LEFT  = 2'd2;

    localparam logic [1:0] REG_FG    = 2'd0;
    localparam logic [1:0] REG_BG    = 2'd1;
    localparam logic [1:0] REG_SHOWN = 2'd2;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_EXEC, S_SCRL_RD, S_SCRL_WR, S_FILL, S_READ, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture the item, compute cursor
        logic              cell_wr;   // write the single item cell
        logic              fill_wr;   // write blank at sweep address
        logic              scrl_rd;   // read cell below sweep address
        logic              scrl_wr;   // write copied or blank cell
        logic              ptr_clr;   // zero the sweep pointer
        logic              ptr_inc;   // advance sweep pointer
        logic              rd_issue;  // issue cell read
        logic              done;      // present result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scroll;
        logic need_clear;
        logic need_read;
        logic ptr_last;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/tcw_ctrl.sv
// Controller FSM for the text console writer.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    output logic          busy,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd  o_cmd
);
    import tcw_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.need_read) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_READ;
                end else if (i_stat.need_clear) begin
                    n_state = S_FILL;
                end else begin
                    o_cmd.cell_wr = 1'b1;
                    n_state = i_stat.need_scroll ? S_SCRL_RD : S_DONE;
                end
            end
            S_SCRL_RD: begin
                o_cmd.scrl_rd = 1'b1;
                n_state = S_SCRL_WR;
            end
            S_SCRL_WR: begin
                o_cmd.scrl_wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCRL_RD;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a started item always returns to idle through the result state
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> (r_state == S_IDLE)) else $error("result not followed by idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !busy) else $error("load while busy");
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.scrl_wr && o_cmd.fill_wr)) else $error("two sweep writes");
endmodule
`default_nettype wire

// File: rtl/core/tcw_dp.sv
// Datapath for the text console writer: cursor, config registers, cell memory, sweeps.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  tcw_pkg::t_cmd               i_cmd,
    output tcw_pkg::t_stat              o_stat,
    input  wire [2:0]                   i_kind,
    input  wire [7:0]                   i_char_code,
    input  wire [7:0]                   i_col,
    input  wire [7:0]                   i_row,
    input  wire [7:0]                   i_attr,
    input  wire [1:0]                   i_direction,
    input  wire                         i_cfg_valid,
    input  wire [1:0]                   i_cfg_index,
    input  wire [3:0]                   i_cfg_data,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::ADDR_W-1:0]  o_cursor_linear,
    output logic                        o_cursor_reg_write,
    output logic [7:0]                  o_cell_char,
    output logic [7:0]                  o_cell_attr
);
    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCRL_END = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] BOT = ADDR_W'(CELLS - COLS);

    logic [3:0] r_fg, r_bg;
    logic       r_shown;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [2:0]  r_kind;
    logic [7:0]  r_wch, n_wch, r_wat, n_wat;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic        r_wen, n_wen, r_scroll, n_scroll, r_read, n_read, r_moved, n_moved;
    logic [ADDR_W-1:0] r_ptr;
    logic [15:0] mem [CELLS];
    logic [15:0] r_rdata;
    logic [7:0]  cur_attr;

    assign cur_attr = {r_bg, r_fg};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd7; r_bg <= 4'd0; r_shown <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FG:    r_fg    <= i_cfg_data;
                REG_BG:    r_bg    <= i_cfg_data;
                REG_SHOWN: r_shown <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // per-item decode: new cursor, cell write, scroll / read flags
    logic [ROW_W:0] row_m, row_p;
    logic [COL_W:0] col_m, col_p;
    logic x_lo, x_hi, y_lo, y_hi;
    always_comb begin
        n_col = r_col; n_row = r_row; n_wen = 1'b0; n_scroll = 1'b0;
        n_read = 1'b0; n_moved = 1'b0;
        n_wch = i_char_code; n_wat = cur_attr;
        n_waddr = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
        row_m = {1'b0, r_row} - 1'b1; row_p = {1'b0, r_row} + 1'b1;
        col_m = {1'b0, r_col} - 1'b1; col_p = {1'b0, r_col} + 1'b1;
        x_lo = 1'b0; x_hi = 1'b0; y_lo = 1'b0; y_hi = 1'b0;
        case (i_kind)
            K_PUT: begin
                n_moved = 1'b1;
                if (i_char_code == 8'd10 || i_char_code == 8'd13) begin
                    n_col = '0;
                    if (row_p >= (ROW_W+1)'(ROWS)) n_scroll = 1'b1;
                    else n_row = row_p[ROW_W-1:0];
                end else begin
                    n_wen = 1'b1;
                    if (col_p >= (COL_W+1)'(COLS)) begin
                        n_col = '0;
                        if (row_p >= (ROW_W+1)'(ROWS)) n_scroll = 1'b1;
                        else n_row = row_p[ROW_W-1:0];
                    end else n_col = col_p[COL_W-1:0];
                end
            end
            K_BS: begin
                n_moved = 1'b1; n_wen = 1'b1; n_wch = BLANK;
                if (r_col != '0) n_col = col_m[COL_W-1:0];
                else if (r_row != '0) begin
                    n_row = row_m[ROW_W-1:0]; n_col = COL_W'(COLS - 1);
                end
                n_waddr = ADDR_W'(n_row) * ADDR_W'(COLS) + ADDR_W'(n_col);
            end
            K_SET: begin
                if (i_col < 8'(COLS) && i_row < 8'(ROWS)) begin
                    n_col = i_col[COL_W-1:0]; n_row = i_row[ROW_W-1:0]; n_moved = 1'b1;
                end
            end
            K_MOVE: begin
                n_moved = 1'b1;
                case (i_direction)
                    D_UP:   begin y_lo = (r_row == '0); n_row = row_m[ROW_W-1:0]; end
                    D_DOWN: begin
                        y_hi = (row_p >= (ROW_W+1)'(ROWS)); n_row = row_p[ROW_W-1:0];
                    end
                    D_LEFT: begin
                        if (r_col == '0) begin
                            y_lo = (r_row == '0); n_row = row_m[ROW_W-1:0];
                            n_col = COL_W'(COLS - 1);
                        end else n_col = col_m[COL_W-1:0];
                        x_lo = 1'b0;
                    end
                    default: begin
                        if (col_p >= (COL_W+1)'(COLS)) begin
                            y_hi = (row_p >= (ROW_W+1)'(ROWS)); n_row = row_p[ROW_W-1:0];
                            n_col = '0;
                        end else n_col = col_p[COL_W-1:0];
                        x_hi = 1'b0;
                    end
                endcase
                if (y_lo || y_hi || x_lo || x_hi) begin
                    n_col = r_col; n_row = r_row; n_moved = 1'b0;
                end
            end
            K_CELL: begin
                n_wat = i_attr;
                n_wen = (i_col < 8'(COLS) && i_row < 8'(ROWS));
                n_waddr = ADDR_W'(i_row) * ADDR_W'(COLS) + ADDR_W'(i_col);
            end
            K_READ: begin
                n_read = (i_col < 8'(COLS) && i_row < 8'(ROWS));
                n_waddr = ADDR_W'(i_row) * ADDR_W'(COLS) + ADDR_W'(i_col);
            end
            default: ;
        endcase
    end

    // item registers and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_kind <= K_PUT;
            r_wen <= 1'b0; r_scroll <= 1'b0; r_read <= 1'b0; r_moved <= 1'b0;
        end else if (i_cmd.load) begin
            r_col <= n_col; r_row <= n_row; r_kind <= i_kind;
            r_wen <= n_wen; r_scroll <= n_scroll; r_read <= n_read; r_moved <= n_moved;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wch <= n_wch; r_wat <= n_wat; r_waddr <= n_waddr;
        end
    end

    // sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ptr_clr) r_ptr <= '0;
        else if (i_cmd.ptr_inc)       r_ptr <= r_ptr + 1'b1;
    end

    assign o_stat.need_scroll = r_scroll;
    assign o_stat.need_clear  = (r_kind == K_CLEAR);
    assign o_stat.need_read   = r_read;
    assign o_stat.ptr_last    = i_cmd.scrl_wr ? (r_ptr == LAST) : (r_ptr == LAST);

    // cell memory: one write port, one registered read port
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0]       wr_data;
    logic              wr_en;
    always_comb begin
        wr_en = 1'b0; wr_addr = r_ptr; wr_data = {cur_attr, BLANK};
        rd_addr = r_waddr;
        if (i_cmd.fill_wr) wr_en = 1'b1;
        else if (i_cmd.cell_wr && r_wen) begin
            wr_en = 1'b1; wr_addr = r_waddr; wr_data = {r_wat, r_wch};
        end else if (i_cmd.scrl_wr) begin
            wr_en = 1'b1;
            if (r_ptr <= SCRL_END) wr_data = r_rdata;
        end
        if (i_cmd.scrl_rd) rd_addr = (r_ptr < BOT) ? r_ptr + ADDR_W'(COLS) : r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.scrl_rd || i_cmd.rd_issue) r_rdata <= mem[rd_addr];
    end

    // result
    logic [ADDR_W-1:0] lin;
    assign lin = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
    assign o_cursor_col       = r_col;
    assign o_cursor_row       = r_row;
    assign o_cursor_linear    = lin;
    assign o_cursor_reg_write = r_moved & r_shown;
    assign o_cell_char        = r_read ? r_rdata[7:0]  : 8'd0;
    assign o_cell_attr        = r_read ? r_rdata[15:8] : 8'd0;

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(COLS)) && (r_row < ROW_W'(ROWS))) else $error("cursor out of range");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST) else $error("sweep pointer out of range");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !(r_read && r_scroll)) else $error("read with scroll");
endmodule
`default_nettype wire

// File: rtl/core/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp.
//
// channel   dir  handshake                  payload
// command   in   start & !busy              i_kind, i_char_code .. i_direction
// result    out  o_done strobe, one cycle   o_cursor_*, o_cell_char, o_cell_attr
// config    in   i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// Plain items: accepted in the idle state, then an execute state, then the result strobe
// from the result state, and back to idle before the next item is taken. Read adds a
// state for the registered cell read. Scroll adds a read and a write state per cell (one
// read port) over all 2000 cells. Clear adds a fill state per cell over all 2000 cells.
// After reset a clearing pass over all cells holds busy high; config waits until idle.
// The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [2:0]  i_kind,
    input  wire [7:0]  i_char_code,
    input  wire [7:0]  i_col,
    input  wire [7:0]  i_row,
    input  wire [7:0]  i_attr,
    input  wire [1:0]  i_direction,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [3:0]  i_cfg_data,
    output logic       o_done,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::ADDR_W-1:0] o_cursor_linear,
    output logic                       o_cursor_reg_write,
    output logic [7:0]                 o_cell_char,
    output logic [7:0]                 o_cell_attr
);
    import tcw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // config only while no item is in flight or being taken
    assign o_cfg_ready = !busy && !start;
    assign o_done      = cmd.done;

    tcw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    tcw_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_kind(i_kind), .i_char_code(i_char_code), .i_col(i_col), .i_row(i_row),
        .i_attr(i_attr), .i_direction(i_direction),
        .i_cfg_valid(i_cfg_valid & o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_cursor_col(o_cursor_col), .o_cursor_row(o_cursor_row),
        .o_cursor_linear(o_cursor_linear), .o_cursor_reg_write(o_cursor_reg_write),
        .o_cell_char(o_cell_char), .o_cell_attr(o_cell_attr)
    );
endmodule
`default_nettype wire
